/* hw/rtl/tcdd_pkg.sv */
// Shared types and constants for the two-channel 3x3 diffuse/decay filter.
// Used by every module under hw/rtl except tcdd_ram; no dependencies.
package tcdd_pkg;

    localparam int ROW_LEN    = 256;
    localparam int ROW_COUNT  = 256;
    localparam int COL_W      = $clog2(ROW_LEN);
    localparam int ROW_W      = $clog2(ROW_COUNT + 2);

    localparam int PIX_W      = 16;
    localparam int WORD_W     = 2 * PIX_W;
    localparam int LINE_W     = 2 * WORD_W;
    localparam int CSUM_W     = PIX_W + 2;
    localparam int SUM_W      = PIX_W + 4;
    localparam int RATE_W     = 13;
    localparam int Q_FRAC     = 12;
    localparam int MIX_W      = PIX_W + RATE_W + 1;
    localparam int MIXQ_W     = MIX_W - Q_FRAC;

    // floor(x / 9) == (x * DIV9_MUL) >> DIV9_SHIFT for x < 2**21
    localparam int DIV9_W     = 20;
    localparam int DIV9_SHIFT = 23;
    localparam int PROD_W     = SUM_W + DIV9_W;
    localparam logic [DIV9_W-1:0] DIV9_MUL = DIV9_W'(932068);

    localparam logic [RATE_W-1:0] ONE_Q12 = RATE_W'(4096);
    localparam logic [PIX_W-1:0]  PIX_MAX = '1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [RATE_W-1:0] RATE_A_RST  = RATE_W'(410);
    localparam logic [PIX_W-1:0]  DECAY_A_RST = PIX_W'(41);
    localparam logic [RATE_W-1:0] RATE_B_RST  = RATE_W'(3277);
    localparam logic [PIX_W-1:0]  DECAY_B_RST = PIX_W'(819);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE_A  = 2'd0,
        CFG_DECAY_A = 2'd1,
        CFG_RATE_B  = 2'd2,
        CFG_DECAY_B = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [RATE_W-1:0] rate_a;
        logic [PIX_W-1:0]  decay_a;
        logic [RATE_W-1:0] rate_b;
        logic [PIX_W-1:0]  decay_b;
    } t_cfg;

    // One window column plus the per-output control for the back end.
    typedef struct packed {
        logic [CSUM_W-1:0] sum_a;
        logic [CSUM_W-1:0] sum_b;
        logic [PIX_W-1:0]  mid_a;
        logic [PIX_W-1:0]  mid_b;
        logic              emit;
        logic              last;
        logic              mask_l;
        logic              mask_r;
    } t_col;

endpackage

/* hw/rtl/two_channel_diffuse_decay_3x3.sv */
// Top level of the two-channel 3x3 diffuse/decay filter.
// Uses tcdd_pkg, tcdd_front, tcdd_fifo, tcdd_back (and tcdd_ram via the front).

// Takes one pixel per clock, row by row, for a ROW_LEN x ROW_COUNT frame and
// returns one filtered pixel per clock (while i_stall is low) once the window is
// primed; each result follows the input that completes its 3x3 window,
// which is the pixel one row and one column past it, so a frame must be
// followed by ROW_LEN + 1 flush transactions to drain its last row. Rate is
// one transaction per clock, limited only by the single-port-per-side line
// store RAM; the input stalls only when the 4-entry column queue backs up from
// output stalls. The line store needs no clearing pass after reset. The user must
// write the configuration registers only while the block is idle (not enforced).
module two_channel_diffuse_decay_3x3 (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [tcdd_pkg::PIX_W-1:0]       i_value_a,
    input  logic [tcdd_pkg::PIX_W-1:0]       i_value_b,
    input  logic                             i_is_flush,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [tcdd_pkg::PIX_W-1:0]       o_filtered_a,
    output logic [tcdd_pkg::PIX_W-1:0]       o_filtered_b,
    output logic                             o_frame_last,
    input  logic                             i_cfg_we,
    input  logic [tcdd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tcdd_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    tcdd_pkg::t_cfg                  r_cfg;
    logic                            w_push, w_pop;
    tcdd_pkg::t_col                  w_push_data, w_head;
    logic [tcdd_pkg::FIFO_CW-1:0]    w_fifo_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_a  <= tcdd_pkg::RATE_A_RST;
            r_cfg.decay_a <= tcdd_pkg::DECAY_A_RST;
            r_cfg.rate_b  <= tcdd_pkg::RATE_B_RST;
            r_cfg.decay_b <= tcdd_pkg::DECAY_B_RST;
        end else if (i_cfg_we) begin
            unique case (tcdd_pkg::t_cfg_idx'(i_cfg_idx))
                tcdd_pkg::CFG_RATE_A:  r_cfg.rate_a  <= i_cfg_wdata[tcdd_pkg::RATE_W-1:0];
                tcdd_pkg::CFG_DECAY_A: r_cfg.decay_a <= i_cfg_wdata[tcdd_pkg::PIX_W-1:0];
                tcdd_pkg::CFG_RATE_B:  r_cfg.rate_b  <= i_cfg_wdata[tcdd_pkg::RATE_W-1:0];
                tcdd_pkg::CFG_DECAY_B: r_cfg.decay_b <= i_cfg_wdata[tcdd_pkg::PIX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    tcdd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value_a   (i_value_a),
        .i_value_b   (i_value_b),
        .i_is_flush  (i_is_flush),
        .i_fifo_cnt  (w_fifo_cnt),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    tcdd_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_cnt       (w_fifo_cnt)
    );

    tcdd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_nonempty (w_fifo_cnt != '0),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_filtered_a (o_filtered_a),
        .o_filtered_b (o_filtered_b),
        .o_frame_last (o_frame_last)
    );

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |-> (w_fifo_cnt != tcdd_pkg::FIFO_CW'(tcdd_pkg::FIFO_DEPTH)))
        else $error("column queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (w_fifo_cnt != '0))
        else $error("column queue underflow");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (w_fifo_cnt == $past(w_fifo_cnt) + tcdd_pkg::FIFO_CW'(1)))
        else $error("column queue count mismatch");
`endif

endmodule

/* hw/rtl/tcdd_ram.sv */
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module tcdd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/tcdd_front.sv */
// Front end: accepts pixels, tracks raster position, reads/updates the two-row line
// store and pushes one window column per transaction. Uses tcdd_pkg, tcdd_ram.
module tcdd_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [tcdd_pkg::PIX_W-1:0]        i_value_a,
    input  logic [tcdd_pkg::PIX_W-1:0]        i_value_b,
    input  logic                              i_is_flush,
    input  logic [tcdd_pkg::FIFO_CW-1:0]      i_fifo_cnt,
    output logic                              o_push,
    output tcdd_pkg::t_col                    o_push_data
);

    logic                            w_accept;
    logic                            w_pos_last;
    logic [tcdd_pkg::ROW_W-1:0]      r_in_row, n_in_row;
    logic [tcdd_pkg::COL_W-1:0]      r_in_col, n_in_col;

    logic                            r_f_valid;
    logic [tcdd_pkg::COL_W-1:0]      r_f_col;
    logic [tcdd_pkg::PIX_W-1:0]      r_f_pix_a, r_f_pix_b;
    logic                            r_f_top_ok, r_f_emit, r_f_last, r_f_mask_l, r_f_mask_r;

    logic [tcdd_pkg::LINE_W-1:0]     w_rd_data;
    logic [tcdd_pkg::WORD_W-1:0]     w_top, w_mid, w_bot;
    logic                            w_pix_zero;

    assign o_stall  = ({1'b0, i_fifo_cnt} + {{tcdd_pkg::FIFO_CW{1'b0}}, r_f_valid})
                      >= (tcdd_pkg::FIFO_CW + 1)'(tcdd_pkg::FIFO_DEPTH);
    assign w_accept   = i_valid && !o_stall;
    assign w_pos_last = (r_in_row == tcdd_pkg::ROW_W'(tcdd_pkg::ROW_COUNT + 1));
    assign w_pix_zero = i_is_flush || (r_in_row >= tcdd_pkg::ROW_W'(tcdd_pkg::ROW_COUNT));

    always_comb begin
        n_in_row = r_in_row;
        n_in_col = r_in_col;
        if (w_accept) begin
            priority if (w_pos_last) begin
                n_in_row = '0;
                n_in_col = '0;
            end else if (r_in_col == tcdd_pkg::COL_W'(tcdd_pkg::ROW_LEN - 1)) begin
                n_in_row = r_in_row + tcdd_pkg::ROW_W'(1);
                n_in_col = '0;
            end else begin
                n_in_col = r_in_col + tcdd_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_f_valid <= 1'b0;
        end else begin
            r_in_row  <= n_in_row;
            r_in_col  <= n_in_col;
            r_f_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_f_col    <= r_in_col;
            r_f_pix_a  <= w_pix_zero ? '0 : i_value_a;
            r_f_pix_b  <= w_pix_zero ? '0 : i_value_b;
            r_f_top_ok <= r_in_row >= tcdd_pkg::ROW_W'(2);
            r_f_emit   <= (r_in_row >= tcdd_pkg::ROW_W'(2))
                          || ((r_in_row == tcdd_pkg::ROW_W'(1)) && (r_in_col != '0));
            r_f_last   <= w_pos_last;
            r_f_mask_l <= r_in_col == tcdd_pkg::COL_W'(1);
            r_f_mask_r <= r_in_col == '0;
        end
    end

    // Upper word: row two above the input, lower word: row one above.
    tcdd_ram #(
        .WIDTH (tcdd_pkg::LINE_W),
        .DEPTH (tcdd_pkg::ROW_LEN)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_f_valid),
        .i_wr_addr (r_f_col),
        .i_wr_data ({w_mid, w_bot}),
        .i_rd_en   (w_accept),
        .i_rd_addr (r_in_col),
        .o_rd_data (w_rd_data)
    );

    assign w_top = r_f_top_ok ? w_rd_data[tcdd_pkg::LINE_W-1:tcdd_pkg::WORD_W] : '0;
    assign w_mid = w_rd_data[tcdd_pkg::WORD_W-1:0];
    assign w_bot = {r_f_pix_b, r_f_pix_a};

    always_comb begin
        o_push_data.sum_a  = tcdd_pkg::CSUM_W'(w_top[tcdd_pkg::PIX_W-1:0])
                           + tcdd_pkg::CSUM_W'(w_mid[tcdd_pkg::PIX_W-1:0])
                           + tcdd_pkg::CSUM_W'(w_bot[tcdd_pkg::PIX_W-1:0]);
        o_push_data.sum_b  = tcdd_pkg::CSUM_W'(w_top[tcdd_pkg::WORD_W-1:tcdd_pkg::PIX_W])
                           + tcdd_pkg::CSUM_W'(w_mid[tcdd_pkg::WORD_W-1:tcdd_pkg::PIX_W])
                           + tcdd_pkg::CSUM_W'(w_bot[tcdd_pkg::WORD_W-1:tcdd_pkg::PIX_W]);
        o_push_data.mid_a  = w_mid[tcdd_pkg::PIX_W-1:0];
        o_push_data.mid_b  = w_mid[tcdd_pkg::WORD_W-1:tcdd_pkg::PIX_W];
        o_push_data.emit   = r_f_emit;
        o_push_data.last   = r_f_last;
        o_push_data.mask_l = r_f_mask_l;
        o_push_data.mask_r = r_f_mask_r;
    end

    assign o_push = r_f_valid;

endmodule

/* hw/rtl/tcdd_fifo.sv */
// Small column queue between front and back end.
// Uses tcdd_pkg.
module tcdd_fifo (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  tcdd_pkg::t_col               i_push_data,
    input  logic                         i_pop,
    output tcdd_pkg::t_col               o_head,
    output logic [tcdd_pkg::FIFO_CW-1:0] o_cnt
);

    tcdd_pkg::t_col                  r_mem [tcdd_pkg::FIFO_DEPTH];
    logic [tcdd_pkg::FIFO_AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [tcdd_pkg::FIFO_CW-1:0]    r_cnt, n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + tcdd_pkg::FIFO_CW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - tcdd_pkg::FIFO_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + tcdd_pkg::FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + tcdd_pkg::FIFO_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_head = r_mem[r_rd_ptr];
    assign o_cnt  = r_cnt;

endmodule

/* hw/rtl/tcdd_back.sv */
// Back end: window shift, 3x3 sum, divide by 9, lerp, saturate, decay and output register.
// Uses tcdd_pkg.
module tcdd_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tcdd_pkg::t_cfg             i_cfg,
    input  logic                       i_q_nonempty,
    input  tcdd_pkg::t_col             i_head,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [tcdd_pkg::PIX_W-1:0] o_filtered_a,
    output logic [tcdd_pkg::PIX_W-1:0] o_filtered_b,
    output logic                       o_frame_last
);

    logic w_en;

    // two most recent columns: c1 older, c0 newer
    logic [tcdd_pkg::CSUM_W-1:0] r_c1_sa, r_c1_sb, r_c0_sa, r_c0_sb;
    logic [tcdd_pkg::PIX_W-1:0]  r_c0_mid_a, r_c0_mid_b;

    logic [tcdd_pkg::CSUM_W-1:0] w_left_a, w_left_b, w_right_a, w_right_b;

    logic                        r_s1_valid, r_s1_last;
    logic [tcdd_pkg::SUM_W-1:0]  r_s1_sum_a, r_s1_sum_b;
    logic [tcdd_pkg::PIX_W-1:0]  r_s1_old_a, r_s1_old_b;

    logic [tcdd_pkg::PROD_W-1:0] w_prod_a, w_prod_b;
    logic                        r_s2_valid, r_s2_last;
    logic [tcdd_pkg::PIX_W-1:0]  r_s2_mean_a, r_s2_mean_b, r_s2_old_a, r_s2_old_b;

    logic [tcdd_pkg::RATE_W-1:0] w_rate_a, w_rate_b;
    logic [tcdd_pkg::MIX_W-1:0]  w_mix_a, w_mix_b;
    logic                        r_s3_valid, r_s3_last;
    logic [tcdd_pkg::MIXQ_W-1:0] r_s3_mix_a, r_s3_mix_b;

    logic [tcdd_pkg::PIX_W-1:0]  w_sat_a, w_sat_b;
    logic                        r_o_valid, r_o_last;
    logic [tcdd_pkg::PIX_W-1:0]  r_o_a, r_o_b;

    assign w_en  = !r_o_valid || !i_stall;
    assign o_pop = w_en && i_q_nonempty;

    assign w_left_a  = i_head.mask_l ? '0 : r_c1_sa;
    assign w_left_b  = i_head.mask_l ? '0 : r_c1_sb;
    assign w_right_a = i_head.mask_r ? '0 : i_head.sum_a;
    assign w_right_b = i_head.mask_r ? '0 : i_head.sum_b;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_c1_sa    <= r_c0_sa;
            r_c1_sb    <= r_c0_sb;
            r_c0_sa    <= i_head.sum_a;
            r_c0_sb    <= i_head.sum_b;
            r_c0_mid_a <= i_head.mid_a;
            r_c0_mid_b <= i_head.mid_b;
        end
    end

    assign w_prod_a = tcdd_pkg::PROD_W'(r_s1_sum_a) * tcdd_pkg::PROD_W'(tcdd_pkg::DIV9_MUL);
    assign w_prod_b = tcdd_pkg::PROD_W'(r_s1_sum_b) * tcdd_pkg::PROD_W'(tcdd_pkg::DIV9_MUL);

    assign w_rate_a = (i_cfg.rate_a > tcdd_pkg::ONE_Q12) ? tcdd_pkg::ONE_Q12 : i_cfg.rate_a;
    assign w_rate_b = (i_cfg.rate_b > tcdd_pkg::ONE_Q12) ? tcdd_pkg::ONE_Q12 : i_cfg.rate_b;

    assign w_mix_a = tcdd_pkg::MIX_W'(r_s2_old_a) * tcdd_pkg::MIX_W'(tcdd_pkg::ONE_Q12 - w_rate_a)
                   + tcdd_pkg::MIX_W'(r_s2_mean_a) * tcdd_pkg::MIX_W'(w_rate_a);
    assign w_mix_b = tcdd_pkg::MIX_W'(r_s2_old_b) * tcdd_pkg::MIX_W'(tcdd_pkg::ONE_Q12 - w_rate_b)
                   + tcdd_pkg::MIX_W'(r_s2_mean_b) * tcdd_pkg::MIX_W'(w_rate_b);

    assign w_sat_a = (r_s3_mix_a > tcdd_pkg::MIXQ_W'(tcdd_pkg::PIX_MAX))
                     ? tcdd_pkg::PIX_MAX : r_s3_mix_a[tcdd_pkg::PIX_W-1:0];
    assign w_sat_b = (r_s3_mix_b > tcdd_pkg::MIXQ_W'(tcdd_pkg::PIX_MAX))
                     ? tcdd_pkg::PIX_MAX : r_s3_mix_b[tcdd_pkg::PIX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= o_pop && i_head.emit;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_o_valid  <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_last   <= i_head.last;
            r_s1_sum_a  <= tcdd_pkg::SUM_W'(w_left_a) + tcdd_pkg::SUM_W'(r_c0_sa)
                         + tcdd_pkg::SUM_W'(w_right_a);
            r_s1_sum_b  <= tcdd_pkg::SUM_W'(w_left_b) + tcdd_pkg::SUM_W'(r_c0_sb)
                         + tcdd_pkg::SUM_W'(w_right_b);
            r_s1_old_a  <= r_c0_mid_a;
            r_s1_old_b  <= r_c0_mid_b;

            r_s2_last   <= r_s1_last;
            r_s2_mean_a <= w_prod_a[tcdd_pkg::DIV9_SHIFT +: tcdd_pkg::PIX_W];
            r_s2_mean_b <= w_prod_b[tcdd_pkg::DIV9_SHIFT +: tcdd_pkg::PIX_W];
            r_s2_old_a  <= r_s1_old_a;
            r_s2_old_b  <= r_s1_old_b;

            r_s3_last   <= r_s2_last;
            r_s3_mix_a  <= w_mix_a[tcdd_pkg::MIX_W-1:tcdd_pkg::Q_FRAC];
            r_s3_mix_b  <= w_mix_b[tcdd_pkg::MIX_W-1:tcdd_pkg::Q_FRAC];

            r_o_last    <= r_s3_last;
            r_o_a       <= (i_cfg.decay_a >= w_sat_a) ? '0 : w_sat_a - i_cfg.decay_a;
            r_o_b       <= (i_cfg.decay_b >= w_sat_b) ? '0 : w_sat_b - i_cfg.decay_b;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_filtered_a = r_o_a;
    assign o_filtered_b = r_o_b;
    assign o_frame_last = r_o_last;

endmodule
